>>> src/mtes_pkg.sv
package mtes_pkg;

  localparam int unsigned TimeW  = 28;
  localparam int unsigned SeqLen = 10;
  localparam int unsigned EvMax  = 6;
  localparam int unsigned VlqMax = 4;

  localparam logic OpEvent  = 1'b0;
  localparam logic OpMarker = 1'b1;

  localparam logic [7:0] StatusMask = 8'hf0;
  localparam logic [7:0] NoteOff    = 8'h80;
  localparam logic [7:0] NoteOn     = 8'h90;
  localparam logic [7:0] ContBit    = 8'h80;

  // one queued event: bytes in output order and how many of them there are
  typedef struct packed {
    logic [SeqLen-1:0][7:0] seq;
    logic [3:0]             n;
  } desc_t;

endpackage

>>> src/mtes_if.sv
interface mtes_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [27:0] event_time;
  logic [7:0]  status_byte;
  logic [7:0]  data_byte1;
  logic [7:0]  data_byte2;
  logic [7:0]  data_byte3;
  logic [7:0]  data_byte4;
  logic [7:0]  data_byte5;
  logic [2:0]  byte_count;

  modport source (
    output valid, operation, event_time, status_byte, data_byte1, data_byte2,
           data_byte3, data_byte4, data_byte5, byte_count,
    input  ready
  );
  modport sink (
    input  valid, operation, event_time, status_byte, data_byte1, data_byte2,
           data_byte3, data_byte4, data_byte5, byte_count,
    output ready
  );
endinterface

interface mtes_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last_byte;
  logic [31:0] track_size;

  modport source (
    output valid, out_byte, last_byte, track_size,
    input  ready
  );
  modport sink (
    input  valid, out_byte, last_byte, track_size,
    output ready
  );
endinterface

>>> src/mtes_fifo.sv
module mtes_fifo #(
  parameter int unsigned WIDTH = 84,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] rdata
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r;
  logic [PtrW-1:0]  rd_ptr_r;
  logic [CntW-1:0]  cnt_r;
  logic [PtrW-1:0]  wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == CntW'(DEPTH));
  assign valid   = (cnt_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  assign wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        mem_r[wr_ptr_r] <= wdata;
        wr_ptr_r        <= wr_ptr_nxt;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> src/mtes_front.sv
module mtes_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  mtes_in_if.sink         in_ch,
  input  logic            q_full,
  output logic            q_push,
  output mtes_pkg::desc_t q_desc
);

  logic [mtes_pkg::TimeW-1:0] prev_time_r;
  logic                       marker_seen_r;
  logic                       gating_r;

  logic                       acc;
  logic                       gated;
  logic                       is_note;
  logic [mtes_pkg::TimeW-1:0] delta;
  logic [2:0]                 vlq_n;
  logic [2:0]                 cnt;
  logic [mtes_pkg::VlqMax-1:0][7:0] vlq;
  logic [mtes_pkg::EvMax-1:0][7:0]  ev;
  logic [6:0]                 g0;
  logic [6:0]                 g1;
  logic [6:0]                 g2;
  logic [6:0]                 g3;
  logic [3:0]                 pos;
  logic [3:0]                 rel;

  assign in_ch.ready = !q_full;
  assign acc         = in_ch.valid && in_ch.ready;

  assign gated   = gating_r && !marker_seen_r;
  assign is_note = ((in_ch.status_byte & mtes_pkg::StatusMask) == mtes_pkg::NoteOff) ||
                   ((in_ch.status_byte & mtes_pkg::StatusMask) == mtes_pkg::NoteOn);

  // delta clamps at zero when time runs backwards, and is zero while gated
  always_comb begin
    if (gated || (in_ch.event_time < prev_time_r)) begin
      delta = '0;
    end else begin
      delta = in_ch.event_time - prev_time_r;
    end
  end

  assign g0 = delta[6:0];
  assign g1 = delta[13:7];
  assign g2 = delta[20:14];
  assign g3 = delta[27:21];

  always_comb begin
    if (g3 != '0) begin
      vlq_n = 3'd4;
    end else if (g2 != '0) begin
      vlq_n = 3'd3;
    end else if (g1 != '0) begin
      vlq_n = 3'd2;
    end else begin
      vlq_n = 3'd1;
    end
  end

  always_comb begin
    vlq = '0;
    case (vlq_n)
      3'd4: begin
        vlq[0] = mtes_pkg::ContBit | {1'b0, g3};
        vlq[1] = mtes_pkg::ContBit | {1'b0, g2};
        vlq[2] = mtes_pkg::ContBit | {1'b0, g1};
        vlq[3] = {1'b0, g0};
      end
      3'd3: begin
        vlq[0] = mtes_pkg::ContBit | {1'b0, g2};
        vlq[1] = mtes_pkg::ContBit | {1'b0, g1};
        vlq[2] = {1'b0, g0};
      end
      3'd2: begin
        vlq[0] = mtes_pkg::ContBit | {1'b0, g1};
        vlq[1] = {1'b0, g0};
      end
      default: begin
        vlq[0] = {1'b0, g0};
      end
    endcase
  end

  assign ev[0] = in_ch.status_byte;
  assign ev[1] = in_ch.data_byte1;
  assign ev[2] = in_ch.data_byte2;
  assign ev[3] = in_ch.data_byte3;
  assign ev[4] = in_ch.data_byte4;
  assign ev[5] = in_ch.data_byte5;

  assign cnt = (in_ch.byte_count == 3'd7) ? 3'd6 : in_ch.byte_count;

  // delta bytes first, event bytes right behind them
  always_comb begin
    q_desc.seq = '0;
    q_desc.n   = {1'b0, vlq_n} + {1'b0, cnt};
    pos        = '0;
    rel        = '0;
    for (int k = 0; k < mtes_pkg::SeqLen; k++) begin
      pos = 4'(k);
      rel = pos - {1'b0, vlq_n};
      if (pos < {1'b0, vlq_n}) begin
        q_desc.seq[k] = vlq[pos[1:0]];
      end else if (rel < 4'(mtes_pkg::EvMax)) begin
        q_desc.seq[k] = ev[rel[2:0]];
      end
    end
  end

  assign q_push   = acc && (in_ch.operation == mtes_pkg::OpEvent) && !(gated && is_note);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_time_r   <= '0;
      marker_seen_r <= 1'b0;
      gating_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        gating_r <= cfg_wdata;
      end
      if (acc) begin
        if (in_ch.operation == mtes_pkg::OpMarker) begin
          marker_seen_r <= 1'b1;
        end else begin
          prev_time_r <= in_ch.event_time;
        end
      end
    end
  end

endmodule

>>> src/mtes_back.sv
module mtes_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  mtes_pkg::desc_t q_desc,
  output logic            q_pop,
  mtes_out_if.source      out_ch
);

  mtes_pkg::desc_t cur_r;
  logic            cur_valid_r;
  logic [3:0]      idx_r;
  logic            out_valid_r;
  logic [7:0]      byte_r;
  logic            last_r;
  logic [31:0]     size_r;
  logic [31:0]     total_r;
  logic [31:0]     total_nxt;
  logic            adv;
  logic            is_last;

  assign adv       = cur_valid_r && (!out_valid_r || out_ch.ready);
  assign is_last   = (idx_r == (cur_r.n - 4'd1));
  assign q_pop     = q_valid && (!cur_valid_r || (adv && is_last));
  assign total_nxt = total_r + 32'd1;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = byte_r;
  assign out_ch.last_byte  = last_r;
  assign out_ch.track_size = size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      if (adv) begin
        out_valid_r <= 1'b1;
        byte_r      <= cur_r.seq[idx_r];
        last_r      <= is_last;
        size_r      <= total_nxt;
        total_r     <= total_nxt;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        cur_r       <= q_desc;
        cur_valid_r <= 1'b1;
        idx_r       <= '0;
      end else if (adv) begin
        idx_r <= idx_r + 4'd1;
        if (is_last) begin
          cur_valid_r <= 1'b0;
        end
      end
    end
  end

endmodule

>>> src/midi_track_event_serializer_top.sv
// Serializes time-ordered MIDI events into track bytes: each event emits its
// delta time as a 1 to 4 byte variable-length quantity followed by 0 to 6
// event bytes, one byte per output transfer, with last_byte on the final byte
// and track_size giving the running byte count. The front end takes one input
// item per cycle while the event queue (QUEUE_DEPTH entries) has room; markers
// and gated note events are consumed there and produce no output. The back
// end sends one byte per cycle through its output register while the receiver
// is ready, so an event takes 1 to 10 output bytes (delta bytes plus event
// bytes), and the output rate sets the sustained throughput. Gating changes
// through cfg_we/cfg_wdata apply to later items.
module midi_track_event_serializer_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  mtes_in_if.sink    in_ch,
  mtes_out_if.source out_ch
);

  mtes_pkg::desc_t push_desc;
  mtes_pkg::desc_t pop_desc;
  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_valid;

  mtes_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_desc    (push_desc)
  );

  mtes_fifo #(
    .WIDTH ($bits(mtes_pkg::desc_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_desc),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (pop_desc)
  );

  mtes_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_desc  (pop_desc),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> src/mtes_checker.sv
module mtes_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_last,
  input logic [31:0] out_size
);

  logic [31:0] last_size_r;
  logic        any_in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_size_r <= '0;
      any_in_r    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        last_size_r <= out_size;
      end
      if (in_valid && in_ready) begin
        any_in_r <= 1'b1;
      end
    end
  end

  // track size counts up by one on every byte transfer
  a_size_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |-> (out_size == last_size_r + 32'd1))
    else $error("track_size did not advance by one");

  // no output before any input transfer
  a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> any_in_r)
    else $error("output valid without any input transfer");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      ($stable(out_byte) && $stable(out_last) && $stable(out_size)))
    else $error("output payload changed while stalled");

endmodule

bind midi_track_event_serializer_top mtes_checker u_mtes_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.last_byte),
  .out_size  (out_ch.track_size)
);

>>> tb/sv/tb_mtes_sb_pkg.sv
`timescale 1ns / 100ps

package tb_mtes_sb_pkg;
  import mtes_pkg::*;

  typedef struct packed {
    logic                   op;
    logic [TimeW-1:0]       tick;
    logic [EvMax-1:0][7:0]  ev;
    logic [2:0]             cnt;
  } midi_item_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [31:0] total;
  } track_byte_t;

  class track_scoreboard;
    logic [TimeW-1:0] prev_tick;
    bit               marker_seen;
    logic [31:0]      byte_total;
    bit               gating;
    track_byte_t      due_bytes[$];
    int               errors;

    function new();
      prev_tick   = '0;
      marker_seen = 1'b0;
      byte_total  = '0;
      gating      = 1'b0;
      errors      = 0;
    endfunction

    function void set_gating(bit value);
      gating = value;
    endfunction

    function int pending();
      return due_bytes.size();
    endfunction

    // returns the number of track bytes this item emits
    function int note_item(midi_item_t it);
      logic [7:0]       seq[$];
      logic [TimeW-1:0] delta;
      logic [7:0]       byte_v;
      logic [7:0]       kind;
      bit               gated;
      int               len;
      int               n_ev;
      if (it.op == OpMarker) begin
        marker_seen = 1'b1;
        return 0;
      end
      gated = gating && !marker_seen;
      delta = (it.tick >= prev_tick) ? it.tick - prev_tick : '0;
      if (gated) delta = '0;
      prev_tick = it.tick;
      kind = it.ev[0] & StatusMask;
      if (gated && (kind == NoteOn || kind == NoteOff)) return 0;

      len = 1;
      if (delta >= 28'd128) len = 2;
      if (delta >= 28'd16384) len = 3;
      if (delta >= 28'd2097152) len = 4;
      for (int k = len - 1; k >= 0; k--) begin
        byte_v = 8'(delta >> (7 * k)) & 8'h7f;
        if (k > 0) byte_v = byte_v | ContBit;
        seq.push_back(byte_v);
      end
      n_ev = (it.cnt > EvMax) ? EvMax : int'(it.cnt);
      for (int k = 0; k < n_ev; k++) seq.push_back(it.ev[k]);

      foreach (seq[k]) begin
        byte_total = byte_total + 32'd1;
        due_bytes.push_back('{data: seq[k], last: (k == seq.size() - 1), total: byte_total});
      end
      return seq.size();
    endfunction

    function void check_byte(logic [7:0] data, logic last, logic [31:0] total);
      track_byte_t exp_b;
      if (due_bytes.size() == 0) begin
        $error("out_byte: no transfer expected, got %0h", data);
        errors++;
        return;
      end
      exp_b = due_bytes.pop_front();
      if (data !== exp_b.data) begin
        $error("out_byte: expected %0h, got %0h", exp_b.data, data);
        errors++;
      end
      if (last !== exp_b.last) begin
        $error("last_byte: expected %0b, got %0b", exp_b.last, last);
        errors++;
      end
      if (total !== exp_b.total) begin
        $error("track_size: expected %0d, got %0d", exp_b.total, total);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> tb/sv/tb_midi_track_event_serializer_top.sv
`timescale 1ns / 100ps

module tb_midi_track_event_serializer_top;
  import mtes_pkg::*;
  import tb_mtes_sb_pkg::*;

  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 24;
  localparam logic [TimeW-1:0] TickMax = 28'h0fffffff;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  mtes_in_if  in_ch();
  mtes_out_if out_ch();

  midi_track_event_serializer_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  track_scoreboard  sb;
  logic [TimeW-1:0] now_tick;
  bit               steady;
  bit               hold_req;
  int               last_emitted;
  int               idle_cycles;
  int               stall_left;
  int               run_left;

  always #6 clk = ~clk;

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic midi_item_t random_item(int marker_pct);
    midi_item_t it;
    logic [TimeW:0] next;
    int r;
    for (int k = 0; k < EvMax; k++) it.ev[k] = 8'($urandom_range(0, 255));
    it.cnt  = 3'($urandom_range(0, 7));
    it.tick = 28'($urandom_range(0, TickMax));
    it.op   = OpEvent;
    if ($urandom_range(0, 99) < marker_pct) begin
      it.op = OpMarker;
      return it;
    end
    r = $urandom_range(0, 99);
    if (r < 30) it.ev[0] = NoteOn | 8'($urandom_range(0, 15));
    else if (r < 50) it.ev[0] = NoteOff | 8'($urandom_range(0, 15));
    else if (r < 60) it.ev[0] = 8'hff;
    if ($urandom_range(0, 99) < 70) it.cnt = 3'($urandom_range(1, 3));
    r = $urandom_range(0, 99);
    if (r < 25) next = {1'b0, now_tick};
    else if (r < 55) next = {1'b0, now_tick} + 29'($urandom_range(1, 127));
    else if (r < 75) next = {1'b0, now_tick} + 29'($urandom_range(128, 16383));
    else if (r < 88) next = {1'b0, now_tick} + 29'($urandom_range(16384, 2097151));
    else if (r < 95) next = {1'b0, now_tick} + 29'($urandom_range(2097152, TickMax));
    else next = {1'b0, it.tick};
    if (next > {1'b0, TickMax}) next = {1'b0, it.tick};
    it.tick  = next[TimeW-1:0];
    now_tick = it.tick;
    return it;
  endfunction

  // sender: called at a falling edge, returns at a falling edge
  task automatic send_item(input midi_item_t it);
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= it.op;
    in_ch.event_time  <= it.tick;
    in_ch.status_byte <= it.ev[0];
    in_ch.data_byte1  <= it.ev[1];
    in_ch.data_byte2  <= it.ev[2];
    in_ch.data_byte3  <= it.ev[3];
    in_ch.data_byte4  <= it.ev[4];
    in_ch.data_byte5  <= it.ev[5];
    in_ch.byte_count  <= it.cnt;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    last_emitted = sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic send_gapped(input midi_item_t it);
    int n;
    n = gap_len();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    send_item(it);
  endtask

  task automatic send_ev(input logic [TimeW-1:0] tick, input logic [7:0] st,
                         input logic [2:0] cnt, input logic [39:0] data);
    midi_item_t it;
    it.op    = OpEvent;
    it.tick  = tick;
    it.ev    = {data, st};
    it.cnt   = cnt;
    now_tick = tick;
    send_gapped(it);
  endtask

  task automatic random_run(input int target, input int marker_pct);
    int done;
    done = 0;
    while (done < target) begin
      send_gapped(random_item(marker_pct));
      if (last_emitted > 0) done++;
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_gating(input bit value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_gating(value);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req   = 1'b0;
      stall_left = HoldCycles;
    end
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if (run_left > 0) begin
        run_left--;
      end else begin
        stall_left = gap_len();
        run_left   = $urandom_range(0, 12);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      sb.check_byte(out_ch.out_byte, out_ch.last_byte, out_ch.track_size);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles == StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    sb                = new();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OpEvent;
    in_ch.event_time  = '0;
    in_ch.status_byte = '0;
    in_ch.data_byte1  = '0;
    in_ch.data_byte2  = '0;
    in_ch.data_byte3  = '0;
    in_ch.data_byte4  = '0;
    in_ch.data_byte5  = '0;
    in_ch.byte_count  = '0;
    out_ch.ready      = 1'b0;
    now_tick          = '0;
    steady            = 1'b0;
    hold_req          = 1'b0;
    idle_cycles       = 0;
    stall_left        = 0;
    run_left          = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // gated until the first marker: notes dropped, deltas zero
    write_gating(1'b1);
    send_ev(28'd1000, 8'h93, 3'd3, 40'h00_00_00_40_3c);
    send_ev(28'd2000, 8'h85, 3'd3, 40'h00_00_00_00_3c);
    send_ev(28'd500000, 8'hb0, 3'd3, 40'h00_00_00_7f_07);
    send_ev(28'd100, 8'hc2, 3'd2, 40'h00_00_00_00_05);
    random_run(20, 0);
    send_gapped(random_item(100));
    send_ev(now_tick, 8'h90, 3'd3, 40'h00_00_00_64_3c);
    send_ev(now_tick + 28'd300, 8'h80, 3'd3, 40'h00_00_00_00_3c);

    drain();
    write_gating(1'b0);
    send_ev(28'd0, 8'hf8, 3'd1, 40'h0);
    send_ev(28'd0, 8'hb1, 3'd0, 40'h00_00_00_01_02);
    send_ev(28'd127, 8'he0, 3'd3, 40'h00_00_00_7f_7f);
    send_ev(28'd255, 8'h9f, 3'd7, 40'hff_ff_ff_ff_ff);
    send_ev(28'd16638, 8'h8f, 3'd4, 40'h00_00_7f_00_7f);
    send_ev(28'd33022, 8'hff, 3'd6, 40'h20_a1_07_03_51);
    send_ev(28'd2130173, 8'h00, 3'd5, 40'h0);
    send_ev(28'd4227325, 8'hff, 3'd6, 40'hff_ff_ff_ff_ff);
    send_ev(TickMax, 8'h90, 3'd3, 40'h00_00_00_7f_7f);
    send_ev(TickMax, 8'h80, 3'd3, 40'h00_00_00_00_7f);
    send_ev(28'd5, 8'ha5, 3'd2, 40'h00_00_00_00_aa);
    send_gapped(random_item(100));

    random_run(50, 6);

    // output held off while the sender keeps pushing
    steady   = 1'b1;
    hold_req = 1'b1;
    random_run(16, 0);
    steady = 1'b0;
    drain();

    write_gating(1'b1);
    random_run(50, 6);
    steady = 1'b1;
    random_run(30, 4);
    steady = 1'b0;
    drain();

    write_gating(1'b0);
    random_run(40, 6);

    in_ch.valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
